FILE: rtl/b2s_pkg.sv
package b2s_pkg;

    localparam int DigestMax = 32;
    localparam int KeyMax    = 32;

    typedef enum logic [1:0] {
        CMD_ABSORB        = 2'd0,
        CMD_ABSORB_FINISH = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_FINISH_ALT    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_OUT_LEN = 3'd0,
        REG_KEY_LEN = 3'd1,
        REG_KEY_W0  = 3'd2,
        REG_KEY_W1  = 3'd3,
        REG_KEY_W2  = 3'd4,
        REG_KEY_W3  = 3'd5
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_COMP_INIT,
        ST_COMP_RUN,
        ST_COMP_END,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic start_msg;   // load IV, key, latch length
        logic put_byte;    // write the input byte at the fill position
        logic pad_final;   // add fill to count, mark final block
        logic comp_init;   // load the working vector
        logic comp_step;   // half of a G mix
        logic comp_end;    // fold into chain value, clear buffer
        logic pre_full;    // add 64 to count before a non-final block
        logic emit_next;   // advance digest byte pointer
    } t_cmd_bus;

    // Datapath to controller status
    typedef struct packed {
        logic buf_full;
        logic mix_last;
        logic emit_last;
    } t_status;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        case (i)
            3'd0: iv_word = 32'h6A09E667;
            3'd1: iv_word = 32'hBB67AE85;
            3'd2: iv_word = 32'h3C6EF372;
            3'd3: iv_word = 32'hA54FF53A;
            3'd4: iv_word = 32'h510E527F;
            3'd5: iv_word = 32'h9B05688C;
            3'd6: iv_word = 32'h1F83D9AB;
            default: iv_word = 32'h5BE0CD19;
        endcase
    endfunction

    // Word positions a,b,c,d of mix j, low nibble first
    function automatic logic [15:0] mix_pos(input logic [2:0] j);
        case (j)
            3'd0: mix_pos = 16'hC840;
            3'd1: mix_pos = 16'hD951;
            3'd2: mix_pos = 16'hEA62;
            3'd3: mix_pos = 16'hFB73;
            3'd4: mix_pos = 16'hFA50;
            3'd5: mix_pos = 16'hCB61;
            3'd6: mix_pos = 16'hD872;
            default: mix_pos = 16'hE943;
        endcase
    endfunction

    function automatic logic [63:0] perm(input logic [3:0] r);
        case (r)
            4'd0: perm = 64'hfedcba9876543210;
            4'd1: perm = 64'h357b20c16df984ae;
            4'd2: perm = 64'h491763eadf250c8b;
            4'd3: perm = 64'h8f04a562ebcd1397;
            4'd4: perm = 64'hd386cb1efa427509;
            4'd5: perm = 64'h91ef57d438b0a6c2;
            4'd6: perm = 64'hb8293670a4def15c;
            4'd7: perm = 64'ha2684f05931ce7bd;
            4'd8: perm = 64'h5a417d2c803b9ef6;
            default: perm = 64'h0dc3e9bf5167482a;
        endcase
    endfunction

endpackage

FILE: rtl/b2s_ctrl.sv
module b2s_ctrl
    import b2s_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_fire,
    input  t_cmd     i_cmd,
    input  logic     i_out_ready,
    input  t_status  i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_cmd_bus o_cmd
);

    t_state r_state, n_state;
    logic   r_in_msg, n_in_msg;
    logic   r_absorb, n_absorb;   // byte pending after a block compression
    logic   r_finish, n_finish;   // finish pending
    logic   r_final, n_final;     // current compression is the last block

    // next state
    always_comb begin
        n_state  = r_state;
        n_in_msg = r_in_msg;
        n_absorb = r_absorb;
        n_finish = r_finish;
        n_final  = r_final;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_in_msg = 1'b1;
                    n_absorb = (i_cmd == CMD_ABSORB) || (i_cmd == CMD_ABSORB_FINISH);
                    n_finish = (i_cmd != CMD_ABSORB);
                    n_state  = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                if (r_absorb && i_stat.buf_full) begin
                    n_final = 1'b0;
                    n_state = ST_COMP_INIT;
                end else if (r_finish) begin
                    n_absorb = 1'b0;
                    n_finish = 1'b0;
                    n_final  = 1'b1;
                    n_state  = ST_COMP_INIT;
                end else begin
                    n_absorb = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            ST_COMP_INIT: n_state = ST_COMP_RUN;
            ST_COMP_RUN:  if (i_stat.mix_last) n_state = ST_COMP_END;
            ST_COMP_END:  n_state = r_final ? ST_EMIT : ST_ABSORB;
            ST_EMIT: begin
                if (i_out_ready && i_stat.emit_last) begin
                    n_in_msg = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.start_msg = i_in_fire && !r_in_msg;
            end
            ST_ABSORB: begin
                if (r_absorb && i_stat.buf_full) begin
                    o_cmd.pre_full = 1'b1;
                end else begin
                    o_cmd.put_byte  = r_absorb;
                    o_cmd.pad_final = r_finish;
                end
            end
            ST_COMP_INIT: o_cmd.comp_init = 1'b1;
            ST_COMP_RUN:  o_cmd.comp_step = 1'b1;
            ST_COMP_END:  o_cmd.comp_end  = 1'b1;
            ST_EMIT: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_next = i_out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_in_msg <= 1'b0;
            r_absorb <= 1'b0;
            r_finish <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_msg <= n_in_msg;
            r_absorb <= n_absorb;
            r_finish <= n_finish;
            r_final  <= n_final;
        end
    end

endmodule

FILE: rtl/b2s_dp.sv
module b2s_dp
    import b2s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_bus    i_cmd,
    input  logic        i_in_fire,
    input  logic [7:0]  i_byte,
    input  logic [5:0]  i_out_len,
    input  logic [5:0]  i_key_len,
    input  logic [255:0] i_key,
    output t_status     o_stat,
    output logic [7:0]  o_digest_byte,
    output logic        o_last_byte
);

    logic [31:0] r_h [8];
    logic [31:0] r_m [16];
    logic [31:0] r_v [16];
    logic [6:0]  r_fill;
    logic [63:0] r_count;
    logic        r_final;
    logic [7:0]  r_byte;
    logic [5:0]  r_len;
    logic [4:0]  r_optr;
    logic [3:0]  r_round;
    logic [2:0]  r_mix;
    logic        r_half;

    logic [5:0]  olen_eff, klen_eff;
    logic [15:0] pos;
    logic [63:0] sched;
    logic [3:0]  ia, ib, ic, id, i0, i1;
    logic [31:0] mw, ga, gdx, gd, gc, gbx, gb;
    logic [31:0] hw;

    assign olen_eff = (i_out_len == 6'd0 || i_out_len > 6'(DigestMax)) ?
                      6'(DigestMax) : i_out_len;
    assign klen_eff = (i_key_len > 6'(KeyMax)) ? 6'(KeyMax) : i_key_len;

    // Half of a G mix on one column or diagonal per step
    assign pos   = mix_pos(r_mix);
    assign ia    = pos[3:0];
    assign ib    = pos[7:4];
    assign ic    = pos[11:8];
    assign id    = pos[15:12];
    assign sched = perm(r_round);
    assign i0    = sched[{r_mix, 3'd0} +: 4];
    assign i1    = sched[{r_mix, 3'd4} +: 4];
    assign mw    = r_half ? r_m[i1] : r_m[i0];
    always_comb begin
        ga  = r_v[ia] + r_v[ib] + mw;
        gdx = r_v[id] ^ ga;
        gd  = r_half ? {gdx[7:0], gdx[31:8]} : {gdx[15:0], gdx[31:16]};
        gc  = r_v[ic] + gd;
        gbx = r_v[ib] ^ gc;
        gb  = r_half ? {gbx[6:0], gbx[31:7]} : {gbx[11:0], gbx[31:12]};
    end

    assign o_stat.buf_full  = r_fill[6];
    assign o_stat.mix_last  = (r_round == 4'd9) && (r_mix == 3'd7) && r_half;
    assign o_stat.emit_last = ({1'b0, r_optr} + 6'd1 == r_len);

    assign hw            = r_h[r_optr[4:2]];
    assign o_digest_byte = hw[{r_optr[1:0], 3'd0} +: 8];
    assign o_last_byte   = o_stat.emit_last;

    // control-free payload state; fill and count cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
            r_len   <= 6'(DigestMax);
            r_optr  <= '0;
            r_round <= '0;
            r_mix   <= '0;
            r_half  <= 1'b0;
            r_final <= 1'b0;
            for (int j = 0; j < 16; j++) r_m[j] <= '0;
        end else begin
            if (i_in_fire) r_byte <= i_byte;
            if (i_cmd.start_msg) begin
                r_len   <= olen_eff;
                r_count <= '0;
                r_optr  <= '0;
                for (int j = 0; j < 8; j++) begin
                    r_h[j] <= iv_word(3'(j)) ^ ((j == 0) ?
                              (32'h01010000 ^ {18'd0, klen_eff, 8'd0} ^ {26'd0, olen_eff})
                              : 32'd0);
                    for (int k = 0; k < 4; k++)
                        r_m[j][8*k +: 8] <= (6'(4*j + k) < klen_eff) ?
                                            i_key[32*j + 8*k +: 8] : 8'd0;
                end
                for (int j = 8; j < 16; j++) r_m[j] <= '0;
                r_fill <= (klen_eff != 6'd0) ? 7'd64 : 7'd0;
            end
            if (i_cmd.pre_full) begin
                r_count <= r_count + 64'd64;
                r_final <= 1'b0;
            end
            if (i_cmd.put_byte) begin
                r_m[r_fill[5:2]][{r_fill[1:0], 3'd0} +: 8] <= r_byte;
                r_fill <= r_fill + 7'd1;
            end
            if (i_cmd.pad_final) begin
                r_count <= r_count + {57'd0, r_fill} + {63'd0, i_cmd.put_byte};
                r_final <= 1'b1;
            end
            if (i_cmd.comp_init) begin
                r_round <= '0;
                r_mix   <= '0;
                r_half  <= 1'b0;
                for (int j = 0; j < 8; j++) begin
                    r_v[j]     <= r_h[j];
                    r_v[j + 8] <= iv_word(3'(j));
                end
                r_v[12] <= iv_word(3'd4) ^ r_count[31:0];
                r_v[13] <= iv_word(3'd5) ^ r_count[63:32];
                r_v[14] <= r_final ? ~iv_word(3'd6) : iv_word(3'd6);
            end
            if (i_cmd.comp_step) begin
                r_v[ia] <= ga;
                r_v[ib] <= gb;
                r_v[ic] <= gc;
                r_v[id] <= gd;
                r_half  <= ~r_half;
                if (r_half) begin
                    r_mix <= r_mix + 3'd1;
                    if (r_mix == 3'd7) r_round <= r_round + 4'd1;
                end
            end
            if (i_cmd.comp_end) begin
                for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] ^ r_v[j] ^ r_v[j + 8];
                for (int j = 0; j < 16; j++) r_m[j] <= '0;
                r_fill <= '0;
                r_optr <= '0;
            end
            if (i_cmd.emit_next) r_optr <= r_optr + 5'd1;
        end
    end

endmodule

FILE: rtl/blake2s_hash.sv
// BLAKE2s hasher (keyed or unkeyed), one message byte per input beat. Command 0
// absorbs a byte, 1 absorbs and finishes, 2 or 3 finish only. A byte that arrives on
// a full 64-byte block first waits for one compression (160 half-G steps on one shared
// mix unit plus count, load and fold steps). Finish runs the final compression before
// the first digest beat is valid; then out_len digest beats follow, byte 0 first,
// tlast on the final one. Registers written take effect at the next message start;
// write them only between messages.
module blake2s_hash
    import b2s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // digest_byte[7:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [5:0]   r_out_len, r_key_len;
    logic [255:0] r_key;
    logic         in_fire;
    t_cmd_bus     cmd;
    t_status      stat;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len <= 6'(DigestMax);
            r_key_len <= '0;
            r_key     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OUT_LEN: r_out_len <= i_cfg_data[5:0];
                REG_KEY_LEN: r_key_len <= i_cfg_data[5:0];
                REG_KEY_W0:  r_key[63:0]    <= i_cfg_data;
                REG_KEY_W1:  r_key[127:64]  <= i_cfg_data;
                REG_KEY_W2:  r_key[191:128] <= i_cfg_data;
                REG_KEY_W3:  r_key[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    b2s_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    b2s_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_fire     (in_fire),
        .i_byte        (s_axis_tdata),
        .i_out_len     (r_out_len),
        .i_key_len     (r_key_len),
        .i_key         (r_key),
        .o_stat        (stat),
        .o_digest_byte (m_axis_tdata),
        .o_last_byte   (m_axis_tlast)
    );

    // no input taken while digest beats are out
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input and output overlap");

    // digest beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest beat changed under stall");

    // last beat ends the output run
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output continued after last");

endmodule
